[rtl/kti_pkg.sv]
// Package for the keyframe track interpolator.
// Holds the item kinds, status codes, controller states and the command and
// status structs shared by the controller and the datapath. No dependencies.
package kti_pkg;

    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_APPEND = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [1:0] STATUS_REJECTED = 2'd2;

    localparam logic [4:0] MOD_FIRST_STEP = 5'd0;
    localparam logic [4:0] DIV_FIRST_STEP = 5'd16;
    localparam logic [4:0] LAST_STEP      = 5'd31;
    localparam logic [1:0] LAST_COORD     = 2'd2;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_RD_LAST,
        OP_APPEND,
        OP_REJECT,
        OP_EMPTY,
        OP_MOD_INIT,
        OP_MOD_STEP,
        OP_MOD_END,
        OP_SRCH_INIT,
        OP_SRCH_RD,
        OP_SRCH_CMP,
        OP_SEL_RD,
        OP_SEL_TAKE,
        OP_P1_RD,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_MUL,
        OP_ACC,
        OP_FINISH
    } dp_op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_RD_LAST,
        S_APPEND_CHK,
        S_MOD_INIT,
        S_MOD,
        S_MOD_END,
        S_SRCH_INIT,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SEL_RD,
        S_SEL_TAKE,
        S_P1_RD,
        S_DIV_INIT,
        S_DIV,
        S_MUL,
        S_ACC,
        S_FINISH
    } state_t;

    typedef struct packed {
        dp_op_t op;
        logic   load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       count_zero;
        logic       full;
        logic       wrap_needed;
        logic       last_lt;
        logic       step_last;
        logic       search_done;
        logic       direct;
        logic       coord_last;
        logic       out_busy;
    } stat_t;

endpackage

[rtl/keyframe_track_interpolator.sv]
// Top level of the keyframe track interpolator.
// Joins kti_ctrl and kti_dp; depends on kti_pkg.
//
//   channel  direction  handshake              payload
//   input    in         in_valid / in_stall    kind, key_time, in_x, in_y, in_z
//   output   out        out_valid / out_stall  out_x, out_y, out_z, status
//   config   in         cfg_wen                cfg_wdata (loop period)
//
// One item is worked on at a time. A query on a non-empty table first wraps
// its time with the 32-step modulo when a loop period is set and the time
// reaches it, then runs a binary search over the single memory read port and
// either returns a stored point or interpolates with the 16-step weight
// divider. Reset empties the table and clears the loop period. A stalled
// output holds its item while the next item is already taken in.
module keyframe_track_interpolator #(
    parameter int MAX_FRAMES = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         kind,
    input  logic [31:0]        key_time,
    input  logic signed [31:0] in_x,
    input  logic signed [31:0] in_y,
    input  logic signed [31:0] in_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z,
    output logic [1:0]         status,
    input  logic               cfg_wen,
    input  logic [31:0]        cfg_wdata
);

    kti_pkg::cmd_t  cmd;
    kti_pkg::stat_t stat;

    kti_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    kti_dp #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .kind      (kind),
        .key_time  (key_time),
        .in_x      (in_x),
        .in_y      (in_y),
        .in_z      (in_z),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_z     (out_z),
        .status    (status)
    );

endmodule

[rtl/kti_ctrl.sv]
// Controller state machine of the keyframe track interpolator.
// Sequences the datapath through commands; depends on kti_pkg.
module kti_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  kti_pkg::stat_t stat,
    output kti_pkg::cmd_t  cmd
);

    kti_pkg::state_t state_reg;
    kti_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kti_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != kti_pkg::S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = kti_pkg::OP_NONE;
        cmd.load   = 1'b0;
        case (state_reg)
            kti_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = kti_pkg::S_DISPATCH;
                end
            end
            kti_pkg::S_DISPATCH:
            begin
                state_next = kti_pkg::S_FINISH;
                case (stat.kind)
                    kti_pkg::KIND_CLEAR:
                    begin
                        cmd.op = kti_pkg::OP_CLEAR;
                    end
                    kti_pkg::KIND_APPEND:
                    begin
                        if (stat.full)
                        begin
                            cmd.op = kti_pkg::OP_REJECT;
                        end
                        else if (stat.count_zero)
                        begin
                            cmd.op = kti_pkg::OP_APPEND;
                        end
                        else
                        begin
                            state_next = kti_pkg::S_RD_LAST;
                        end
                    end
                    kti_pkg::KIND_QUERY:
                    begin
                        if (stat.count_zero)
                        begin
                            cmd.op = kti_pkg::OP_EMPTY;
                        end
                        else if (stat.wrap_needed)
                        begin
                            state_next = kti_pkg::S_MOD_INIT;
                        end
                        else
                        begin
                            state_next = kti_pkg::S_SRCH_INIT;
                        end
                    end
                    default:
                    begin
                        cmd.op = kti_pkg::OP_NONE;
                    end
                endcase
            end
            kti_pkg::S_RD_LAST:
            begin
                cmd.op     = kti_pkg::OP_RD_LAST;
                state_next = kti_pkg::S_APPEND_CHK;
            end
            kti_pkg::S_APPEND_CHK:
            begin
                cmd.op     = stat.last_lt ? kti_pkg::OP_APPEND : kti_pkg::OP_REJECT;
                state_next = kti_pkg::S_FINISH;
            end
            kti_pkg::S_MOD_INIT:
            begin
                cmd.op     = kti_pkg::OP_MOD_INIT;
                state_next = kti_pkg::S_MOD;
            end
            kti_pkg::S_MOD:
            begin
                cmd.op = kti_pkg::OP_MOD_STEP;
                if (stat.step_last)
                begin
                    state_next = kti_pkg::S_MOD_END;
                end
            end
            kti_pkg::S_MOD_END:
            begin
                cmd.op     = kti_pkg::OP_MOD_END;
                state_next = kti_pkg::S_SRCH_INIT;
            end
            kti_pkg::S_SRCH_INIT:
            begin
                cmd.op     = kti_pkg::OP_SRCH_INIT;
                state_next = kti_pkg::S_SRCH_RD;
            end
            kti_pkg::S_SRCH_RD:
            begin
                if (stat.search_done)
                begin
                    state_next = kti_pkg::S_SEL_RD;
                end
                else
                begin
                    cmd.op     = kti_pkg::OP_SRCH_RD;
                    state_next = kti_pkg::S_SRCH_CMP;
                end
            end
            kti_pkg::S_SRCH_CMP:
            begin
                cmd.op     = kti_pkg::OP_SRCH_CMP;
                state_next = kti_pkg::S_SRCH_RD;
            end
            kti_pkg::S_SEL_RD:
            begin
                cmd.op     = kti_pkg::OP_SEL_RD;
                state_next = kti_pkg::S_SEL_TAKE;
            end
            kti_pkg::S_SEL_TAKE:
            begin
                cmd.op     = kti_pkg::OP_SEL_TAKE;
                state_next = stat.direct ? kti_pkg::S_FINISH : kti_pkg::S_P1_RD;
            end
            kti_pkg::S_P1_RD:
            begin
                cmd.op     = kti_pkg::OP_P1_RD;
                state_next = kti_pkg::S_DIV_INIT;
            end
            kti_pkg::S_DIV_INIT:
            begin
                cmd.op     = kti_pkg::OP_DIV_INIT;
                state_next = kti_pkg::S_DIV;
            end
            kti_pkg::S_DIV:
            begin
                cmd.op = kti_pkg::OP_DIV_STEP;
                if (stat.step_last)
                begin
                    state_next = kti_pkg::S_MUL;
                end
            end
            kti_pkg::S_MUL:
            begin
                cmd.op     = kti_pkg::OP_MUL;
                state_next = kti_pkg::S_ACC;
            end
            kti_pkg::S_ACC:
            begin
                cmd.op     = kti_pkg::OP_ACC;
                state_next = stat.coord_last ? kti_pkg::S_FINISH : kti_pkg::S_MUL;
            end
            kti_pkg::S_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    cmd.op     = kti_pkg::OP_FINISH;
                    state_next = kti_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = kti_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[rtl/kti_dp.sv]
// Datapath of the keyframe track interpolator: keyframe memories, search
// bounds, shared shift-subtract divider, blend multiplier and output register.
// Depends on kti_pkg; driven by kti_ctrl.
module kti_dp #(
    parameter int MAX_FRAMES = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  kti_pkg::cmd_t      cmd,
    output kti_pkg::stat_t     stat,
    input  logic               cfg_wen,
    input  logic [31:0]        cfg_wdata,
    input  logic [1:0]         kind,
    input  logic [31:0]        key_time,
    input  logic signed [31:0] in_x,
    input  logic signed [31:0] in_y,
    input  logic signed [31:0] in_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z,
    output logic [1:0]         status
);

    localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CW = $clog2(MAX_FRAMES + 1);

    logic [31:0] mem_t [MAX_FRAMES];
    logic [31:0] mem_x [MAX_FRAMES];
    logic [31:0] mem_y [MAX_FRAMES];
    logic [31:0] mem_z [MAX_FRAMES];

    logic [31:0]        period_reg;
    logic [CW-1:0]      count_reg;
    logic [1:0]         kind_reg;
    logic [31:0]        t_reg;
    logic [31:0]        ix_reg, iy_reg, iz_reg;
    logic [31:0]        rd_t_q, rd_x_q, rd_y_q, rd_z_q;
    logic [AW-1:0]      rd_addr;
    logic [32:0]        rem_reg;
    logic [31:0]        quo_reg;
    logic [4:0]         step_reg;
    logic [31:0]        den_reg;
    logic [CW-1:0]      lo_reg, hi_reg, mid_reg;
    logic [31:0]        t2_reg;
    logic [31:0]        p1_reg [3];
    logic [31:0]        p2_reg [3];
    logic [31:0]        res_reg [3];
    logic [1:0]         res_status_reg;
    logic [1:0]         coord_reg;
    logic signed [49:0] prod_reg;
    logic               out_valid_reg;
    logic [31:0]        out_x_reg, out_y_reg, out_z_reg;
    logic [1:0]         status_reg;

    logic [CW:0]        lo_hi_sum;
    logic [CW-1:0]      mid_next;
    logic [CW-1:0]      last_idx;
    logic [CW-1:0]      lo_minus;
    logic [31:0]        divisor;
    logic [32:0]        rem_shift;
    logic               rem_ge;
    logic signed [32:0] diff;
    logic signed [49:0] prod_next;
    logic signed [49:0] prod_round;
    logic [31:0]        blend_q;

    assign lo_hi_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_next  = lo_hi_sum[CW:1];
    assign last_idx  = count_reg - CW'(1);
    assign lo_minus  = lo_reg - CW'(1);

    always_comb
    begin
        case (cmd.op)
            kti_pkg::OP_RD_LAST: rd_addr = last_idx[AW-1:0];
            kti_pkg::OP_SRCH_RD: rd_addr = mid_next[AW-1:0];
            kti_pkg::OP_SEL_RD:
                rd_addr = (lo_reg == count_reg) ? last_idx[AW-1:0] : lo_reg[AW-1:0];
            kti_pkg::OP_P1_RD:   rd_addr = lo_minus[AW-1:0];
            default:             rd_addr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == kti_pkg::OP_APPEND)
        begin
            mem_t[count_reg[AW-1:0]] <= t_reg;
            mem_x[count_reg[AW-1:0]] <= ix_reg;
            mem_y[count_reg[AW-1:0]] <= iy_reg;
            mem_z[count_reg[AW-1:0]] <= iz_reg;
        end
        rd_t_q <= mem_t[rd_addr];
        rd_x_q <= mem_x[rd_addr];
        rd_y_q <= mem_y[rd_addr];
        rd_z_q <= mem_z[rd_addr];
    end

    assign divisor   = (cmd.op == kti_pkg::OP_DIV_STEP) ? den_reg : period_reg;
    assign rem_shift = {rem_reg[31:0],
                        (cmd.op == kti_pkg::OP_DIV_STEP) ? 1'b0 : quo_reg[31]};
    assign rem_ge    = (rem_shift >= {1'b0, divisor});

    assign diff       = $signed({p2_reg[coord_reg][31], p2_reg[coord_reg]})
                      - $signed({p1_reg[coord_reg][31], p1_reg[coord_reg]});
    assign prod_next  = diff * $signed({1'b0, quo_reg[15:0]});
    assign prod_round = prod_reg + 50'sd32768;
    assign blend_q    = prod_round[47:16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                period_reg <= cfg_wdata;
            end
            if (cmd.op == kti_pkg::OP_CLEAR)
            begin
                count_reg <= '0;
            end
            else if (cmd.op == kti_pkg::OP_APPEND)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.op == kti_pkg::OP_FINISH)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg       <= kind;
            t_reg          <= key_time;
            ix_reg         <= in_x;
            iy_reg         <= in_y;
            iz_reg         <= in_z;
            res_reg[0]     <= '0;
            res_reg[1]     <= '0;
            res_reg[2]     <= '0;
            res_status_reg <= kti_pkg::STATUS_OK;
        end
        case (cmd.op)
            kti_pkg::OP_REJECT: res_status_reg <= kti_pkg::STATUS_REJECTED;
            kti_pkg::OP_EMPTY:  res_status_reg <= kti_pkg::STATUS_EMPTY;
            kti_pkg::OP_MOD_INIT:
            begin
                rem_reg  <= '0;
                quo_reg  <= t_reg;
                step_reg <= kti_pkg::MOD_FIRST_STEP;
            end
            kti_pkg::OP_MOD_STEP, kti_pkg::OP_DIV_STEP:
            begin
                rem_reg  <= rem_ge ? (rem_shift - {1'b0, divisor}) : rem_shift;
                quo_reg  <= {quo_reg[30:0], rem_ge};
                step_reg <= step_reg + 5'd1;
            end
            kti_pkg::OP_MOD_END: t_reg <= rem_reg[31:0];
            kti_pkg::OP_SRCH_INIT:
            begin
                lo_reg <= '0;
                hi_reg <= count_reg;
            end
            kti_pkg::OP_SRCH_RD: mid_reg <= mid_next;
            kti_pkg::OP_SRCH_CMP:
            begin
                if (rd_t_q < t_reg)
                begin
                    lo_reg <= mid_reg + CW'(1);
                end
                else
                begin
                    hi_reg <= mid_reg;
                end
            end
            kti_pkg::OP_SEL_TAKE:
            begin
                res_reg[0] <= rd_x_q;
                res_reg[1] <= rd_y_q;
                res_reg[2] <= rd_z_q;
                p2_reg[0]  <= rd_x_q;
                p2_reg[1]  <= rd_y_q;
                p2_reg[2]  <= rd_z_q;
                t2_reg     <= rd_t_q;
            end
            kti_pkg::OP_DIV_INIT:
            begin
                p1_reg[0] <= rd_x_q;
                p1_reg[1] <= rd_y_q;
                p1_reg[2] <= rd_z_q;
                rem_reg   <= {1'b0, t_reg - rd_t_q};
                den_reg   <= t2_reg - rd_t_q;
                quo_reg   <= '0;
                step_reg  <= kti_pkg::DIV_FIRST_STEP;
                coord_reg <= '0;
            end
            kti_pkg::OP_MUL: prod_reg <= prod_next;
            kti_pkg::OP_ACC:
            begin
                res_reg[coord_reg] <= p1_reg[coord_reg] + blend_q;
                coord_reg          <= coord_reg + 2'd1;
            end
            kti_pkg::OP_FINISH:
            begin
                out_x_reg  <= res_reg[0];
                out_y_reg  <= res_reg[1];
                out_z_reg  <= res_reg[2];
                status_reg <= res_status_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign stat.kind        = kind_reg;
    assign stat.count_zero  = (count_reg == '0);
    assign stat.full        = (count_reg == CW'(MAX_FRAMES));
    assign stat.wrap_needed = (period_reg != '0) && (t_reg >= period_reg);
    assign stat.last_lt     = (rd_t_q < t_reg);
    assign stat.step_last   = (step_reg == kti_pkg::LAST_STEP);
    assign stat.search_done = (lo_reg == hi_reg);
    assign stat.direct      = (lo_reg == count_reg) || (lo_reg == '0) || (rd_t_q == t_reg);
    assign stat.coord_last  = (coord_reg == kti_pkg::LAST_COORD);
    assign stat.out_busy    = out_valid_reg && out_stall;

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_z     = out_z_reg;
    assign status    = status_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_FRAMES))
        else $error("keyframe count above table size");
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == kti_pkg::OP_DIV_STEP) |-> (rem_reg < {1'b0, den_reg}))
        else $error("weight divider remainder not below divisor");
    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == kti_pkg::OP_FINISH) |-> !(out_valid_reg && out_stall))
        else $error("result overwritten while output stalled");
`endif

endmodule

[tb/sv/keyframe_track_interpolator_checker.sv]
// Checker for the keyframe track interpolator: predicts each result from the
// accepted input items and compares it with the output channel.
// Depends on kti_pkg.
`timescale 1ns / 100ps

module keyframe_track_interpolator_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [1:0]         kind,
    input  logic [31:0]        key_time,
    input  logic signed [31:0] in_x,
    input  logic signed [31:0] in_y,
    input  logic signed [31:0] in_z,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [31:0] out_x,
    input  logic signed [31:0] out_y,
    input  logic signed [31:0] out_z,
    input  logic [1:0]         status,
    input  logic               cfg_wen,
    input  logic [31:0]        cfg_wdata,
    output int                 fail_count,
    output int                 pending
);

    localparam int DEPTH = 256;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [1:0]         st;
    } position_t;

    position_t   expected_positions[$];
    logic [31:0] track_time[DEPTH];
    logic [31:0] track_x[DEPTH];
    logic [31:0] track_y[DEPTH];
    logic [31:0] track_z[DEPTH];
    int          track_len;
    logic [31:0] wrap_period;

    assign pending = expected_positions.size();

    function automatic logic signed [31:0] lerp_coord(logic [31:0] a, logic [31:0] b,
                                                      longint w);
        longint p1;
        longint d;
        longint prod;
        p1 = longint'(signed'(a));
        d = longint'(signed'(b)) - p1;
        prod = d * w + 32768;
        return 32'(p1 + (prod >>> 16));
    endfunction

    function automatic position_t track_position(logic [1:0] k, logic [31:0] t,
                                                 logic [31:0] px, logic [31:0] py,
                                                 logic [31:0] pz);
        position_t r;
        int i;
        longint w;
        r = '0;
        r.st = kti_pkg::STATUS_OK;
        if (k == kti_pkg::KIND_CLEAR)
        begin
            track_len = 0;
        end
        else if (k == kti_pkg::KIND_APPEND)
        begin
            if (track_len >= DEPTH || (track_len > 0 && t <= track_time[track_len - 1]))
            begin
                r.st = kti_pkg::STATUS_REJECTED;
            end
            else
            begin
                track_time[track_len] = t;
                track_x[track_len] = px;
                track_y[track_len] = py;
                track_z[track_len] = pz;
                track_len++;
            end
        end
        else if (k == kti_pkg::KIND_QUERY)
        begin
            if (track_len == 0)
            begin
                r.st = kti_pkg::STATUS_EMPTY;
            end
            else
            begin
                if (wrap_period != 0 && t >= wrap_period) t = t % wrap_period;
                i = 0;
                while (i < track_len && track_time[i] < t) i++;
                if (i >= track_len || i == 0 || track_time[i] == t)
                begin
                    if (i >= track_len) i = track_len - 1;
                    r.x = track_x[i];
                    r.y = track_y[i];
                    r.z = track_z[i];
                end
                else
                begin
                    w = (longint'(t - track_time[i - 1]) << 16)
                        / longint'(track_time[i] - track_time[i - 1]);
                    r.x = lerp_coord(track_x[i - 1], track_x[i], w);
                    r.y = lerp_coord(track_y[i - 1], track_y[i], w);
                    r.z = lerp_coord(track_z[i - 1], track_z[i], w);
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        position_t e;
        if (!rst_n)
        begin
            expected_positions.delete();
            track_len = 0;
            wrap_period = '0;
            fail_count = 0;
        end
        else
        begin
            if (cfg_wen) wrap_period = cfg_wdata;
            if (in_valid && !in_stall)
                expected_positions.insert(expected_positions.size(),
                    track_position(kind, key_time, in_x, in_y, in_z));
            if (out_valid && !out_stall)
            begin
                if (expected_positions.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10) $display("unexpected result item");
                end
                else
                begin
                    e = expected_positions.pop_front();
                    if (e.x !== out_x || e.y !== out_y || e.z !== out_z || e.st !== status)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %h %h %h %0d, got %h %h %h %0d",
                                     e.x, e.y, e.z, e.st, out_x, out_y, out_z, status);
                    end
                end
            end
        end
    end

endmodule

[tb/sv/keyframe_track_interpolator_tb.sv]
// Testbench top for the keyframe track interpolator: drives directed and
// random items and loop periods, and gives the verdict.
// Depends on kti_pkg, the block and keyframe_track_interpolator_checker.
`timescale 1ns / 100ps

module keyframe_track_interpolator_tb;

    localparam int STALL_LIMIT = 20000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         kind;
    logic [31:0]        key_time;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [1:0]         status;
    logic               cfg_wen;
    logic [31:0]        cfg_wdata;
    int                 fail_count;
    int                 pending;
    int                 idle_cycles;
    bit                 busy_mode;
    logic [31:0]        last_time;

    keyframe_track_interpolator dut (.*);

    keyframe_track_interpolator_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_stall <= busy_mode ? 1'b0 : ($urandom_range(99) < 11);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("keyframe_track_interpolator_tb: FAIL");
            $finish;
        end
    end

    task automatic send_item(logic [1:0] k, logic [31:0] t, logic [31:0] x,
                             logic [31:0] y, logic [31:0] z);
        while (!busy_mode && $urandom_range(99) < 11)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        key_time <= t;
        in_x <= x;
        in_y <= y;
        in_z <= z;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic set_period(logic [31:0] p);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        cfg_wen <= 1'b1;
        cfg_wdata <= p;
        @(posedge clk);
        cfg_wen <= 1'b0;
    endtask

    task automatic build_track(int n, int step_max);
        send_item(kti_pkg::KIND_CLEAR, $urandom, $urandom, $urandom, $urandom);
        last_time = $urandom_range(3);
        for (int i = 0; i < n; i++)
        begin
            send_item(kti_pkg::KIND_APPEND, last_time, $urandom, $urandom, $urandom);
            last_time = last_time + 1 + $urandom_range(step_max);
        end
    endtask

    initial
    begin
        int n;
        int pick;
        in_valid = 1'b0;
        kind = kti_pkg::KIND_CLEAR;
        key_time = '0;
        in_x = '0;
        in_y = '0;
        in_z = '0;
        cfg_wen = 1'b0;
        cfg_wdata = '0;
        out_stall = 1'b0;
        busy_mode = 1'b0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(kti_pkg::KIND_QUERY, 32'd5, 0, 0, 0);
        send_item(kti_pkg::KIND_APPEND, 32'd100, 32'h7FFFFFFF, 32'h80000000, 32'd0);
        send_item(kti_pkg::KIND_APPEND, 32'd100, 1, 2, 3);
        send_item(kti_pkg::KIND_APPEND, 32'd50, 1, 2, 3);
        send_item(kti_pkg::KIND_APPEND, 32'hFFFFFF00, 32'h80000000, 32'h7FFFFFFF,
                  32'hFFFFFFFF);
        send_item(kti_pkg::KIND_QUERY, 32'd0, 0, 0, 0);
        send_item(kti_pkg::KIND_QUERY, 32'd100, 0, 0, 0);
        send_item(kti_pkg::KIND_QUERY, 32'h80000000, 0, 0, 0);
        send_item(kti_pkg::KIND_QUERY, 32'hFFFFFF00, 0, 0, 0);
        send_item(kti_pkg::KIND_QUERY, 32'hFFFFFFFF, 0, 0, 0);
        send_item(kti_pkg::KIND_UNUSED, 32'hFFFFFFFF, -1, -1, -1);
        send_item(kti_pkg::KIND_CLEAR, 32'd0, 0, 0, 0);
        send_item(kti_pkg::KIND_QUERY, 32'd100, 0, 0, 0);
        set_period(32'hFFFFFFFF);
        send_item(kti_pkg::KIND_APPEND, 32'd0, -5, 5, 7);
        send_item(kti_pkg::KIND_APPEND, 32'd3, 9, -9, 0);
        send_item(kti_pkg::KIND_QUERY, 32'hFFFFFFFF, 0, 0, 0);
        send_item(kti_pkg::KIND_QUERY, 32'hFFFFFFFE, 0, 0, 0);
        set_period(32'd1);
        send_item(kti_pkg::KIND_QUERY, 32'd7, 0, 0, 0);

        // Fill the table to capacity and try one more.
        build_track(256, 3);
        send_item(kti_pkg::KIND_APPEND, 32'hFFFFFFFF, 0, 0, 0);
        send_item(kti_pkg::KIND_QUERY, $urandom_range(last_time), 0, 0, 0);

        for (int phase = 0; phase < 4; phase++)
        begin
            pick = $urandom_range(3);
            set_period(pick == 0 ? 32'd0 : pick == 1 ? $urandom_range(2000, 1)
                       : pick == 2 ? $urandom : 32'hFFFFFFFF);
            busy_mode = (phase == 3);
            for (int b = 0; b < 5; b++)
            begin
                n = $urandom_range(9) == 0 ? $urandom_range(255, 40) : $urandom_range(6);
                build_track(n, $urandom_range(1) ? 400 : 32'h00FFFFFF);
                for (int q = 0; q < 18; q++)
                begin
                    pick = $urandom_range(19);
                    if (pick == 0)
                        send_item(kti_pkg::KIND_APPEND,
                                  $urandom_range(1) ? $urandom : last_time,
                                  $urandom, $urandom, $urandom);
                    else if (pick == 1)
                        send_item(kti_pkg::KIND_UNUSED, $urandom, $urandom, $urandom,
                                  $urandom);
                    else
                        send_item(kti_pkg::KIND_QUERY, $urandom_range(3) == 0 ? $urandom
                                  : $urandom_range(last_time + 500), 0, 0, 0);
                end
            end
            busy_mode = 1'b0;
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("keyframe_track_interpolator_tb: PASS");
        else
            $display("keyframe_track_interpolator_tb: FAIL");
        $finish;
    end

endmodule

[sim.f]
rtl/kti_pkg.sv
rtl/kti_ctrl.sv
rtl/kti_dp.sv
rtl/keyframe_track_interpolator.sv
tb/sv/keyframe_track_interpolator_checker.sv
tb/sv/keyframe_track_interpolator_tb.sv
